// ===== rtl/heartbeat_task_watchdog_defines.svh =====
// ----------------------------------------------------------------------------
// Heartbeat watchdog assertion macros
// Shared concurrent assertion forms for the watchdog RTL.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_TASK_WATCHDOG_DEFINES_SVH
`define HEARTBEAT_TASK_WATCHDOG_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HBW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HBW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hbw_pkg.sv =====
// ----------------------------------------------------------------------------
// Heartbeat watchdog package
// Types, codes and sizing constants shared by the watchdog modules.
// ----------------------------------------------------------------------------
package hbw_pkg;

  localparam int CLIENTS = 8;
  localparam int SLOT_W  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int CNT_W   = $clog2(CLIENTS + 1);

  localparam int CD_W    = 16;
  localparam logic [CD_W-1:0] RESET_CHECK_PERIOD = 16'd4000;
  localparam logic [CD_W-1:0] RESET_WD_TIMEOUT   = 16'd5000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WD_TIMEOUT   = 2'd1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [1:0] FUNC_REGISTER = 2'd0;
  localparam logic [1:0] FUNC_KICK     = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;

  localparam logic [2:0] KIND_REG_ACK  = 3'd0;
  localparam logic [2:0] KIND_KICK_ACK = 3'd1;
  localparam logic [2:0] KIND_STUCK    = 3'd2;
  localparam logic [2:0] KIND_FED      = 3'd3;
  localparam logic [2:0] KIND_EXPIRED  = 3'd4;

  typedef enum logic [1:0] {
    OP_REG,
    OP_KICK,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KICK,
    ST_CHECK,
    ST_WD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] tag;
    logic [31:0] tmo;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } qwr_t;

  typedef struct packed {
    logic empty;
    cmd_t head;
  } qrd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        ok;
    logic [2:0]  slot;
    logic [31:0] tag;
    logic [31:0] elapsed;
  } res_t;

  function automatic logic [2:0] slot3(input logic [CNT_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[2:0];
  endfunction

endpackage

// ===== rtl/hbw_fifo.sv =====
// ----------------------------------------------------------------------------
// Heartbeat watchdog command queue
// Short queue that decouples command decode from command execution.
// ----------------------------------------------------------------------------
`include "heartbeat_task_watchdog_defines.svh"

module hbw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  hbw_pkg::qwr_t wr,
  output logic          full,
  input  logic          pop,
  output hbw_pkg::qrd_t rd
);
  import hbw_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign rd.empty = (cnt_r == '0);
  assign rd.head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr.push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr.push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem_r[wr_ptr_r] <= wr.cmd;
    end
  end

  `HBW_ASSERT_NOW(a_fifo_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH), "queue count over depth")

endmodule

// ===== rtl/hbw_front.sv =====
// ----------------------------------------------------------------------------
// Heartbeat watchdog front end
// Accepts input transactions, decodes the function code, drops unused codes.
// ----------------------------------------------------------------------------
module hbw_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_func,
  input  logic [31:0]   in_client_tag,
  input  logic [31:0]   in_timeout_ms,
  input  logic          q_full,
  output hbw_pkg::qwr_t q_wr
);
  import hbw_pkg::*;

  logic accept;
  logic keep;
  op_t  op;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    keep = 1'b1;
    op   = OP_TICK;
    unique case (in_func)
      FUNC_REGISTER: op = OP_REG;
      FUNC_KICK:     op = OP_KICK;
      FUNC_TICK:     op = OP_TICK;
      FUNC_UNUSED:   keep = 1'b0;
      default:       keep = 1'b0;
    endcase
  end

  assign q_wr.push    = accept && keep;
  assign q_wr.cmd.op  = op;
  assign q_wr.cmd.tag = in_client_tag;
  assign q_wr.cmd.tmo = in_timeout_ms;

endmodule

// ===== rtl/hbw_back.sv =====
// ----------------------------------------------------------------------------
// Heartbeat watchdog back end
// Client table, time base, countdowns and result sequencing.
// ----------------------------------------------------------------------------
`include "heartbeat_task_watchdog_defines.svh"

module hbw_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hbw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbw_pkg::CD_W-1:0]        cfg_data,
  input  hbw_pkg::qrd_t                   q_rd,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hbw_pkg::res_t                   out_res,
  output logic                            out_last
);
  import hbw_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              healthy_r, healthy_nxt;
  logic [31:0]       ktag_r, ktag_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [CD_W-1:0]   chk_cd_r, chk_cd_nxt;
  logic [CD_W-1:0]   wd_cd_r, wd_cd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CD_W-1:0]   period_r;
  logic [CD_W-1:0]   wdto_r;

  logic [31:0]       tags_r [CLIENTS];
  logic [31:0]       tmo_r  [CLIENTS];
  logic [31:0]       kick_r [CLIENTS];

  logic              pend_valid_r, pend_valid_nxt;
  res_t              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              can_emit;
  logic              gen_valid;
  res_t              gen;
  logic              reg_we;
  logic              kick_we;
  logic [SLOT_W-1:0] sidx;
  logic [31:0]       elapsed;
  logic              in_table;

  assign out_free = !out_valid_r || !out_stall;
  assign can_emit = !pend_valid_r || out_free;
  assign sidx     = idx_r[SLOT_W-1:0];
  assign elapsed  = now_r - kick_r[sidx];
  assign in_table = (idx_r < cnt_r);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    healthy_nxt    = healthy_r;
    ktag_nxt       = ktag_r;
    now_nxt        = now_r;
    chk_cd_nxt     = chk_cd_r;
    wd_cd_nxt      = wd_cd_r;
    cnt_nxt        = cnt_r;
    q_pop          = 1'b0;
    reg_we         = 1'b0;
    kick_we        = 1'b0;
    gen_valid      = 1'b0;
    gen            = '0;
    gen.ok         = 1'b1;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_rd.empty) begin
          unique case (q_rd.head.op)
            OP_REG: begin
              gen_valid = 1'b1;
              gen.kind  = KIND_REG_ACK;
              gen.tag   = q_rd.head.tag;
              if (cnt_r < CNT_W'(CLIENTS)) begin
                gen.slot = slot3(cnt_r);
              end else begin
                gen.ok = 1'b0;
              end
              if (can_emit) begin
                q_pop     = 1'b1;
                state_nxt = ST_FINISH;
                if (cnt_r < CNT_W'(CLIENTS)) begin
                  reg_we  = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end
              end
            end
            OP_KICK: begin
              q_pop     = 1'b1;
              ktag_nxt  = q_rd.head.tag;
              idx_nxt   = '0;
              state_nxt = ST_KICK;
            end
            OP_TICK: begin
              q_pop   = 1'b1;
              now_nxt = now_r + 32'd1;
              if (chk_cd_r <= CD_W'(1)) begin
                chk_cd_nxt  = period_r;
                idx_nxt     = '0;
                healthy_nxt = 1'b1;
                state_nxt   = ST_CHECK;
              end else begin
                chk_cd_nxt = chk_cd_r - 1'b1;
                state_nxt  = ST_WD;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_KICK: begin
        if (in_table) begin
          if (tags_r[sidx] == ktag_r) begin
            gen_valid = 1'b1;
            gen.kind  = KIND_KICK_ACK;
            gen.slot  = slot3(idx_r);
            gen.tag   = ktag_r;
            if (can_emit) begin
              kick_we   = 1'b1;
              state_nxt = ST_FINISH;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          gen_valid = 1'b1;
          gen.kind  = KIND_KICK_ACK;
          gen.ok    = 1'b0;
          gen.tag   = ktag_r;
          if (can_emit) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_CHECK: begin
        if (in_table) begin
          if (elapsed > tmo_r[sidx]) begin
            gen_valid   = 1'b1;
            gen.kind    = KIND_STUCK;
            gen.slot    = slot3(idx_r);
            gen.tag     = tags_r[sidx];
            gen.elapsed = elapsed;
            if (can_emit) begin
              idx_nxt     = idx_r + 1'b1;
              healthy_nxt = 1'b0;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (healthy_r) begin
          gen_valid = 1'b1;
          gen.kind  = KIND_FED;
          if (can_emit) begin
            wd_cd_nxt = wdto_r;
            state_nxt = ST_FINISH;
          end
        end else begin
          state_nxt = ST_WD;
        end
      end
      ST_WD: begin
        if (wd_cd_r <= CD_W'(1)) begin
          gen_valid = 1'b1;
          gen.kind  = KIND_EXPIRED;
          if (can_emit) begin
            wd_cd_nxt = wdto_r;
            state_nxt = ST_FINISH;
          end
        end else begin
          wd_cd_nxt = wd_cd_r - 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (pend_valid_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_nxt        = pend_r;
            out_last_nxt   = 1'b1;
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // hold each new result until the next one shows whether it closes the item
    if (gen_valid && can_emit) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = gen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      healthy_r    <= 1'b1;
      now_r        <= '0;
      chk_cd_r     <= RESET_CHECK_PERIOD;
      wd_cd_r      <= RESET_WD_TIMEOUT;
      cnt_r        <= '0;
      period_r     <= RESET_CHECK_PERIOD;
      wdto_r       <= RESET_WD_TIMEOUT;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      healthy_r    <= healthy_nxt;
      now_r        <= now_nxt;
      chk_cd_r     <= chk_cd_nxt;
      wd_cd_r      <= wd_cd_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHECK_PERIOD: period_r <= cfg_data;
          REG_WD_TIMEOUT:   wdto_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ktag_r     <= ktag_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (reg_we) begin
      tags_r[cnt_r[SLOT_W-1:0]] <= q_rd.head.tag;
      tmo_r[cnt_r[SLOT_W-1:0]]  <= q_rd.head.tmo;
      kick_r[cnt_r[SLOT_W-1:0]] <= now_r;
    end
    if (kick_we) begin
      kick_r[sidx] <= now_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

  `HBW_ASSERT_NOW(a_idle_no_pend, state_r == ST_IDLE, !pend_valid_r, "result held in idle")
  `HBW_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CLIENTS), "client count over table size")
  `HBW_ASSERT_NOW(a_scan_idx, state_r == ST_KICK || state_r == ST_CHECK, idx_r <= cnt_r,
    "scan index past client count")
  `HBW_ASSERT_NEXT(a_finish_idle, state_r == ST_FINISH && !pend_valid_r, state_r == ST_IDLE,
    "finish without held result did not return to idle")

endmodule

// ===== rtl/heartbeat_task_watchdog.sv =====
// The back end finishes one item before it takes the next; kick and tick items scan the client
// table one slot per cycle, unless out_stall holds back a result that the scan must emit.
// Results leave through a registered output; a 2-entry queue takes items while one executes.
// Reset (rst_n low, synchronous): time and client count cleared, countdowns and config
// registers reloaded to 4000 and 5000; client table contents are not cleared.
// ----------------------------------------------------------------------------
// Heartbeat task watchdog
// Per-client heartbeat supervision with periodic health check and main watchdog.
// ----------------------------------------------------------------------------
module heartbeat_task_watchdog (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbw_pkg::CD_W-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [31:0]                   in_client_tag,
  input  logic [31:0]                   in_timeout_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_kind,
  output logic                          out_ok,
  output logic [2:0]                    out_slot,
  output logic [31:0]                   out_tag_out,
  output logic [31:0]                   out_elapsed_ms,
  output logic                          out_last
);
  import hbw_pkg::*;

  qwr_t q_wr;
  qrd_t q_rd;
  logic q_full;
  logic q_pop;
  res_t res;

  hbw_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_client_tag (in_client_tag),
    .in_timeout_ms (in_timeout_ms),
    .q_full        (q_full),
    .q_wr          (q_wr)
  );

  hbw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rd    (q_rd)
  );

  hbw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_kind       = res.kind;
  assign out_ok         = res.ok;
  assign out_slot       = res.slot;
  assign out_tag_out    = res.tag;
  assign out_elapsed_ms = res.elapsed;

endmodule
